### hw/rtl/jcb_pkg.sv
package jcb_pkg;

	localparam logic CFG_BLIND_ENABLE = 1'b0;
	localparam logic CFG_ZEXT_ENABLE  = 1'b1;

	localparam logic [3:0] REG_AX      = 4'd11;
	localparam logic [3:0] PSEUDO_FUNC = 4'd4;

	localparam logic [7:0] OP_LD_SECOND = 8'h00;
	localparam logic [7:0] OP_LD_IMM64  = 8'h18;
	localparam logic [7:0] OP_MOV32_K   = 8'hb4;
	localparam logic [7:0] OP_MOV64_K   = 8'hb7;
	localparam logic [7:0] OP_XOR32_K   = 8'ha4;
	localparam logic [7:0] OP_XOR64_K   = 8'ha7;
	localparam logic [7:0] OP_LSH64_K   = 8'h67;
	localparam logic [7:0] OP_MOV64_X   = 8'hbf;
	localparam logic [7:0] OP_MOV32_X   = 8'hbc;
	localparam logic [7:0] OP_OR64_X    = 8'h4f;
	localparam logic [7:0] OP_XOR64_X   = 8'haf;

	localparam logic [7:0] OP_ST_W  = 8'h62;
	localparam logic [7:0] OP_ST_H  = 8'h6a;
	localparam logic [7:0] OP_ST_B  = 8'h72;
	localparam logic [7:0] OP_ST_DW = 8'h7a;

	localparam logic [7:0] ALU_ADD = 8'h00;
	localparam logic [7:0] ALU_SUB = 8'h10;
	localparam logic [7:0] ALU_MUL = 8'h20;
	localparam logic [7:0] ALU_DIV = 8'h30;
	localparam logic [7:0] ALU_OR  = 8'h40;
	localparam logic [7:0] ALU_AND = 8'h50;
	localparam logic [7:0] ALU_MOD = 8'h90;
	localparam logic [7:0] ALU_XOR = 8'ha0;
	localparam logic [7:0] ALU_MOV = 8'hb0;

	localparam logic [7:0] JMP_JEQ  = 8'h10;
	localparam logic [7:0] JMP_JGT  = 8'h20;
	localparam logic [7:0] JMP_JGE  = 8'h30;
	localparam logic [7:0] JMP_JSET = 8'h40;
	localparam logic [7:0] JMP_JNE  = 8'h50;
	localparam logic [7:0] JMP_JSGT = 8'h60;
	localparam logic [7:0] JMP_JSGE = 8'h70;
	localparam logic [7:0] JMP_JLT  = 8'ha0;
	localparam logic [7:0] JMP_JLE  = 8'hb0;
	localparam logic [7:0] JMP_JSLT = 8'hc0;
	localparam logic [7:0] JMP_JSLE = 8'hd0;

	localparam logic [7:0] SFX_ALU32_X = 8'h0c;
	localparam logic [7:0] SFX_ALU64_X = 8'h0f;
	localparam logic [7:0] SFX_JMP_X   = 8'h0d;
	localparam logic [7:0] SFX_JMP32_X = 8'h0e;
	localparam logic [7:0] ST_SIZE_MASK = 8'h18;
	localparam logic [7:0] STX_MEM_BASE = 8'h63;

	localparam logic [2:0] CLS_ALU   = 3'd4;
	localparam logic [2:0] CLS_JMP   = 3'd5;
	localparam logic [2:0] CLS_JMP32 = 3'd6;
	localparam logic [2:0] CLS_ALU64 = 3'd7;

	localparam logic [31:0] AX_SHIFT    = 32'd32;
	localparam logic [31:0] ZEXT_IMM    = 32'd1;
	localparam logic [15:0] BACK_JMP_FIX = 16'd2;

	typedef enum logic [1:0] {
		MAIN_NONE,
		MAIN_PASS,
		MAIN_BLIND3,
		MAIN_LDPAIR
	} main_kind_t;

	typedef struct packed {
		logic        pfx;
		logic [3:0]  p_dst;
		logic [3:0]  p_src;
		logic [15:0] p_off;
		logic [31:0] p_imm;
		logic [31:0] p_rnd;
		main_kind_t  kind;
		logic [7:0]  op;
		logic [7:0]  op2;
		logic [3:0]  dst;
		logic [3:0]  src;
		logic [15:0] off;
		logic [31:0] imm;
		logic [31:0] rnd;
		logic        zext;
	} job_t;

endpackage

### hw/rtl/jit_constant_blinding_rewriter_unit.sv
// Rewrites an eBPF instruction stream with constant blinding. One instruction
// (plus its random word) is taken per cycle while the job queue between the
// classifier and the emitter has room; the emitter sends one instruction per
// cycle while out_stall is low. A pass-through item yields one instruction,
// a blinded immediate three, and a 64-bit load pair five, seven or eight
// (its first half yields nothing on its own; an unpaired first half adds one
// to the item after it). The emitter's one-per-cycle output register sets the
// sustained rate; QUEUE_DEPTH jobs of slack let the input run ahead of a stalled
// output. Jobs pass through the queue, then the output register. Write
// blind_enable (index 0) and zext_enable (index 1) only while the block is idle.
module jit_constant_blinding_rewriter_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         opcode,
	input  logic [3:0]         dest_reg,
	input  logic [3:0]         source_reg,
	input  logic signed [15:0] offset,
	input  logic signed [31:0] immediate,
	input  logic [31:0]        random_word,
	input  logic               end_of_program,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_opcode,
	output logic [3:0]         out_dest,
	output logic [3:0]         out_source,
	output logic signed [15:0] out_offset,
	output logic signed [31:0] out_immediate,
	output logic               last_of_run
);

	logic          blind_q;
	logic          zext_q;
	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;
	jcb_pkg::job_t wr_job;
	jcb_pkg::job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blind_q <= 1'b0;
			zext_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == jcb_pkg::CFG_BLIND_ENABLE) begin
				blind_q <= cfg_data;
			end else begin
				zext_q <= cfg_data;
			end
		end
	end

	jcb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.dest_reg       (dest_reg),
		.source_reg     (source_reg),
		.offset         (offset),
		.immediate      (immediate),
		.random_word    (random_word),
		.end_of_program (end_of_program),
		.blind_en       (blind_q),
		.zext_en        (zext_q),
		.full           (full),
		.push           (push),
		.job            (wr_job)
	);

	jcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	jcb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_opcode    (out_opcode),
		.out_dest      (out_dest),
		.out_source    (out_source),
		.out_offset    (out_offset),
		.out_immediate (out_immediate),
		.last_of_run   (last_of_run)
	);

endmodule

### hw/rtl/jcb_front.sv
module jcb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        opcode,
	input  logic [3:0]        dest_reg,
	input  logic [3:0]        source_reg,
	input  logic [15:0]       offset,
	input  logic [31:0]       immediate,
	input  logic [31:0]       random_word,
	input  logic              end_of_program,
	input  logic              blind_en,
	input  logic              zext_en,
	input  logic              full,
	output logic              push,
	output jcb_pkg::job_t     job
);

	logic        pend_q;
	logic        skip_q;
	logic [3:0]  pend_dst_q;
	logic [3:0]  pend_src_q;
	logic [15:0] pend_off_q;
	logic [31:0] pend_imm_q;
	logic [31:0] pend_rnd_q;

	logic        accept;
	logic        pend_n;
	logic        skip_n;
	logic        hold;
	logic        normal;
	logic [2:0]  cls;
	logic [7:0]  opbits;
	logic [31:0] masked;
	logic [15:0] jmp_off;
	logic        ax_use;
	logic        alu_k;
	logic        jmp_k;
	logic        st_k;
	logic        no_reg;

	assign accept   = in_valid && !full;
	assign in_stall = full;
	assign cls      = opcode[2:0];
	assign opbits   = {opcode[7:4], 4'h0};
	assign masked   = random_word ^ immediate;
	assign jmp_off  = offset[15] ? offset - jcb_pkg::BACK_JMP_FIX : offset;
	assign ax_use   = (dest_reg == jcb_pkg::REG_AX) || (source_reg == jcb_pkg::REG_AX);
	assign no_reg   = !opcode[3];

	always_comb begin
		case (opbits) inside
			jcb_pkg::ALU_ADD, jcb_pkg::ALU_SUB, jcb_pkg::ALU_MUL, jcb_pkg::ALU_DIV,
			jcb_pkg::ALU_OR, jcb_pkg::ALU_AND, jcb_pkg::ALU_MOD, jcb_pkg::ALU_XOR,
			jcb_pkg::ALU_MOV: alu_k = 1'b1;
			default: alu_k = 1'b0;
		endcase
		case (opbits) inside
			jcb_pkg::JMP_JEQ, jcb_pkg::JMP_JGT, jcb_pkg::JMP_JGE, jcb_pkg::JMP_JSET,
			jcb_pkg::JMP_JNE, jcb_pkg::JMP_JSGT, jcb_pkg::JMP_JSGE, jcb_pkg::JMP_JLT,
			jcb_pkg::JMP_JLE, jcb_pkg::JMP_JSLT, jcb_pkg::JMP_JSLE: jmp_k = 1'b1;
			default: jmp_k = 1'b0;
		endcase
		case (opcode) inside
			jcb_pkg::OP_ST_W, jcb_pkg::OP_ST_H, jcb_pkg::OP_ST_B,
			jcb_pkg::OP_ST_DW: st_k = 1'b1;
			default: st_k = 1'b0;
		endcase
	end

	always_comb begin
		job       = '0;
		job.p_dst = pend_dst_q;
		job.p_src = pend_src_q;
		job.p_off = pend_off_q;
		job.p_imm = pend_imm_q;
		job.p_rnd = pend_rnd_q;
		job.op    = opcode;
		job.dst   = dest_reg;
		job.src   = source_reg;
		job.off   = offset;
		job.imm   = immediate;
		job.rnd   = random_word;
		job.zext  = zext_en;
		job.kind  = jcb_pkg::MAIN_NONE;
		pend_n    = pend_q;
		skip_n    = skip_q;
		hold      = 1'b0;
		normal    = 1'b1;
		if (skip_q) begin
			skip_n   = 1'b0;
			job.kind = jcb_pkg::MAIN_PASS;
			normal   = 1'b0;
		end else if (pend_q) begin
			pend_n = 1'b0;
			if (opcode == jcb_pkg::OP_LD_SECOND) begin
				job.kind = jcb_pkg::MAIN_LDPAIR;
				normal   = 1'b0;
			end else begin
				job.pfx = 1'b1;
			end
		end
		if (normal) begin
			if (!blind_en || opcode == jcb_pkg::OP_LD_SECOND) begin
				job.kind = jcb_pkg::MAIN_PASS;
			end else if (opcode == jcb_pkg::OP_LD_IMM64) begin
				if (source_reg == jcb_pkg::PSEUDO_FUNC || ax_use) begin
					job.kind = jcb_pkg::MAIN_PASS;
					skip_n   = 1'b1;
				end else if (end_of_program) begin
					job.kind = jcb_pkg::MAIN_PASS;
				end else begin
					hold   = 1'b1;
					pend_n = 1'b1;
				end
			end else if (ax_use) begin
				job.kind = jcb_pkg::MAIN_PASS;
			end else if (immediate == '0 &&
				(opcode == jcb_pkg::OP_MOV32_K || opcode == jcb_pkg::OP_MOV64_K)) begin
				job.kind = jcb_pkg::MAIN_PASS;
				job.op   = jcb_pkg::OP_XOR64_X;
				job.src  = dest_reg;
				job.off  = '0;
				job.imm  = '0;
			end else if (no_reg && alu_k &&
				(cls == jcb_pkg::CLS_ALU || cls == jcb_pkg::CLS_ALU64)) begin
				job.kind = jcb_pkg::MAIN_BLIND3;
				job.op   = (cls == jcb_pkg::CLS_ALU) ? jcb_pkg::OP_MOV32_K : jcb_pkg::OP_MOV64_K;
				job.op2  = opbits | ((cls == jcb_pkg::CLS_ALU) ? jcb_pkg::SFX_ALU32_X
					: jcb_pkg::SFX_ALU64_X);
				job.off  = '0;
				job.imm  = masked;
			end else if (no_reg && jmp_k &&
				(cls == jcb_pkg::CLS_JMP || cls == jcb_pkg::CLS_JMP32)) begin
				job.kind = jcb_pkg::MAIN_BLIND3;
				job.op   = (cls == jcb_pkg::CLS_JMP) ? jcb_pkg::OP_MOV64_K : jcb_pkg::OP_MOV32_K;
				job.op2  = opbits | ((cls == jcb_pkg::CLS_JMP) ? jcb_pkg::SFX_JMP_X
					: jcb_pkg::SFX_JMP32_X);
				job.off  = jmp_off;
				job.imm  = masked;
			end else if (st_k) begin
				job.kind = jcb_pkg::MAIN_BLIND3;
				job.op   = jcb_pkg::OP_MOV64_K;
				job.op2  = (opcode & jcb_pkg::ST_SIZE_MASK) | jcb_pkg::STX_MEM_BASE;
				job.imm  = masked;
			end else begin
				job.kind = jcb_pkg::MAIN_PASS;
			end
		end
		if (end_of_program) begin
			pend_n = 1'b0;
			skip_n = 1'b0;
		end
	end

	assign push = accept && (job.pfx || job.kind != jcb_pkg::MAIN_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_n;
			skip_q <= skip_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold) begin
			pend_dst_q <= dest_reg;
			pend_src_q <= source_reg;
			pend_off_q <= offset;
			pend_imm_q <= immediate;
			pend_rnd_q <= random_word;
		end
	end

	a_hold_skip_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && skip_q))
		else $error("held load half and skip flag set together");

	a_hold_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hold && !pend_q && !skip_q) |-> !push)
		else $error("transaction pushed for a held load half");

endmodule

### hw/rtl/jcb_queue.sv
module jcb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jcb_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output jcb_pkg::job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jcb_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

### hw/rtl/jcb_back.sv
module jcb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jcb_pkg::job_t      head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_opcode,
	output logic [3:0]         out_dest,
	output logic [3:0]         out_source,
	output logic signed [15:0] out_offset,
	output logic signed [31:0] out_immediate,
	output logic               last_of_run
);

	logic [2:0]  step_q;
	logic        pfx_done_q;
	logic        out_valid_q;
	logic [7:0]  op_q;
	logic [3:0]  dst_q;
	logic [3:0]  src_q;
	logic [15:0] off_q;
	logic [31:0] imm_q;
	logic        last_q;

	logic        load;
	logic        advance;
	logic        ax_use;
	logic        in_pfx;
	logic [7:0]  e_op;
	logic [3:0]  e_dst;
	logic [3:0]  e_src;
	logic [15:0] e_off;
	logic [31:0] e_imm;
	logic        e_last;

	assign load    = !out_valid_q || !out_stall;
	assign advance = load && head_valid;
	assign pop     = advance && e_last;
	assign in_pfx  = head_job.pfx && !pfx_done_q;
	assign ax_use  = (head_job.dst == jcb_pkg::REG_AX) || (head_job.src == jcb_pkg::REG_AX);

	always_comb begin
		e_op   = head_job.op;
		e_dst  = jcb_pkg::REG_AX;
		e_src  = '0;
		e_off  = '0;
		e_imm  = '0;
		e_last = 1'b0;
		if (in_pfx) begin
			e_op   = jcb_pkg::OP_LD_IMM64;
			e_dst  = head_job.p_dst;
			e_src  = head_job.p_src;
			e_off  = head_job.p_off;
			e_imm  = head_job.p_imm;
			e_last = (head_job.kind == jcb_pkg::MAIN_NONE);
		end else begin
			unique case (head_job.kind) inside
				jcb_pkg::MAIN_NONE, jcb_pkg::MAIN_PASS: begin
					e_dst  = head_job.dst;
					e_src  = head_job.src;
					e_off  = head_job.off;
					e_imm  = head_job.imm;
					e_last = 1'b1;
				end
				jcb_pkg::MAIN_BLIND3: begin
					unique case (step_q)
						3'd0: e_imm = head_job.imm;
						3'd1: begin
							e_op  = (head_job.op == jcb_pkg::OP_MOV32_K) ? jcb_pkg::OP_XOR32_K
								: jcb_pkg::OP_XOR64_K;
							e_imm = head_job.rnd;
						end
						default: begin
							e_op   = head_job.op2;
							e_dst  = head_job.dst;
							e_src  = jcb_pkg::REG_AX;
							e_off  = head_job.off;
							e_last = 1'b1;
						end
					endcase
				end
				jcb_pkg::MAIN_LDPAIR: begin
					unique case (step_q)
						3'd0: begin
							e_op  = jcb_pkg::OP_MOV64_K;
							e_imm = head_job.p_rnd ^ head_job.imm;
						end
						3'd1: begin
							e_op  = jcb_pkg::OP_XOR64_K;
							e_imm = head_job.p_rnd;
						end
						3'd2: begin
							e_op  = jcb_pkg::OP_LSH64_K;
							e_imm = jcb_pkg::AX_SHIFT;
						end
						3'd3: begin
							e_op  = jcb_pkg::OP_MOV64_X;
							e_dst = head_job.p_dst;
							e_src = jcb_pkg::REG_AX;
						end
						3'd4: begin
							if (ax_use) begin
								e_op   = head_job.op;
								e_dst  = head_job.dst;
								e_src  = head_job.src;
								e_off  = head_job.off;
								e_imm  = head_job.imm;
								e_last = 1'b1;
							end else begin
								e_op  = jcb_pkg::OP_MOV32_K;
								e_imm = head_job.rnd ^ head_job.p_imm;
							end
						end
						3'd5: begin
							e_op  = jcb_pkg::OP_XOR32_K;
							e_imm = head_job.rnd;
						end
						3'd6: begin
							if (head_job.zext) begin
								e_op  = jcb_pkg::OP_MOV32_X;
								e_src = jcb_pkg::REG_AX;
								e_imm = jcb_pkg::ZEXT_IMM;
							end else begin
								e_op   = jcb_pkg::OP_OR64_X;
								e_dst  = head_job.p_dst;
								e_src  = jcb_pkg::REG_AX;
								e_last = 1'b1;
							end
						end
						default: begin
							e_op   = jcb_pkg::OP_OR64_X;
							e_dst  = head_job.p_dst;
							e_src  = jcb_pkg::REG_AX;
							e_last = 1'b1;
						end
					endcase
				end
				default: e_last = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			pfx_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (advance) begin
				if (e_last) begin
					step_q     <= '0;
					pfx_done_q <= 1'b0;
				end else if (in_pfx) begin
					pfx_done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_q   <= e_op;
			dst_q  <= e_dst;
			src_q  <= e_src;
			off_q  <= e_off;
			imm_q  <= e_imm;
			last_q <= e_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_opcode    = op_q;
	assign out_dest      = dst_q;
	assign out_source    = src_q;
	assign out_offset    = off_q;
	assign out_immediate = imm_q;
	assign last_of_run   = last_q;

	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0 && !pfx_done_q))
		else $error("sequencer not restarted after pop");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && last_of_run))
		else $error("final transaction of a run not marked last");

endmodule

### sim/tb_jit_constant_blinding_rewriter_unit.sv
module tb_jit_constant_blinding_rewriter_unit;

	localparam logic [7:0] OPBITS_MASK = 8'hf0;

	localparam logic [7:0] OP_ADD64_K  = 8'h07;
	localparam logic [7:0] OP_ADD32_K  = 8'h04;
	localparam logic [7:0] OP_JEQ_K    = 8'h15;
	localparam logic [7:0] OP_JGT_K    = 8'h25;
	localparam logic [7:0] OP_JSLT32_K = 8'hc6;
	localparam logic [7:0] OP_JA       = 8'h05;
	localparam logic [7:0] OP_CALL     = 8'h85;
	localparam logic [7:0] OP_EXIT     = 8'h95;

	typedef struct packed {
		logic [7:0]  op;
		logic [3:0]  dst;
		logic [3:0]  src;
		logic [15:0] off;
		logic [31:0] imm;
		logic [31:0] rnd;
		logic        eop;
	} insn_t;

	typedef struct packed {
		logic [7:0]  op;
		logic [3:0]  dst;
		logic [3:0]  src;
		logic [15:0] off;
		logic [31:0] imm;
		logic        last;
	} rewr_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	class rewrite_scoreboard;
		rewr_t rewrites_due[$];
		rewr_t run_q[$];
		bit blind_en;
		bit zext_en;
		bit held_valid;
		bit skip_next_insn;
		logic [3:0] held_dst;
		logic [3:0] held_src;
		logic [15:0] held_off;
		logic [31:0] held_imm;
		logic [31:0] held_rnd;
		int mismatch_count;

		function void put(logic [7:0] op, logic [3:0] dst, logic [3:0] src,
				logic [15:0] off, logic [31:0] imm);
			rewr_t r;
			r.op = op;
			r.dst = dst;
			r.src = src;
			r.off = off;
			r.imm = imm;
			r.last = 1'b0;
			run_q.push_back(r);
		endfunction

		function void put_raw(insn_t it);
			put(it.op, it.dst, it.src, it.off, it.imm);
		endfunction

		function bit uses_ax(insn_t it);
			return it.dst == jcb_pkg::REG_AX || it.src == jcb_pkg::REG_AX;
		endfunction

		function bit alu_k(logic [7:0] ob);
			case (ob) inside
				jcb_pkg::ALU_ADD, jcb_pkg::ALU_SUB, jcb_pkg::ALU_MUL, jcb_pkg::ALU_DIV,
				jcb_pkg::ALU_OR, jcb_pkg::ALU_AND, jcb_pkg::ALU_MOD, jcb_pkg::ALU_XOR,
				jcb_pkg::ALU_MOV: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function bit jmp_k(logic [7:0] ob);
			case (ob) inside
				jcb_pkg::JMP_JEQ, jcb_pkg::JMP_JGT, jcb_pkg::JMP_JGE, jcb_pkg::JMP_JSET,
				jcb_pkg::JMP_JNE, jcb_pkg::JMP_JSGT, jcb_pkg::JMP_JSGE, jcb_pkg::JMP_JLT,
				jcb_pkg::JMP_JLE, jcb_pkg::JMP_JSLT, jcb_pkg::JMP_JSLE: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void blind_one(insn_t it);
			logic [2:0] cls;
			logic [7:0] ob;
			logic [31:0] masked;
			logic [15:0] noff;
			cls = it.op[2:0];
			ob = it.op & OPBITS_MASK;
			masked = it.rnd ^ it.imm;
			noff = it.off[15] ? it.off - jcb_pkg::BACK_JMP_FIX : it.off;
			if (uses_ax(it)) begin
				put_raw(it);
			end else if (it.imm == 32'd0 &&
					(it.op == jcb_pkg::OP_MOV32_K || it.op == jcb_pkg::OP_MOV64_K)) begin
				put(jcb_pkg::OP_XOR64_X, it.dst, it.dst, '0, '0);
			end else if (!it.op[3] && cls == jcb_pkg::CLS_ALU && alu_k(ob)) begin
				put(jcb_pkg::OP_MOV32_K, jcb_pkg::REG_AX, '0, '0, masked);
				put(jcb_pkg::OP_XOR32_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
				put(ob | jcb_pkg::SFX_ALU32_X, it.dst, jcb_pkg::REG_AX, '0, '0);
			end else if (!it.op[3] && cls == jcb_pkg::CLS_ALU64 && alu_k(ob)) begin
				put(jcb_pkg::OP_MOV64_K, jcb_pkg::REG_AX, '0, '0, masked);
				put(jcb_pkg::OP_XOR64_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
				put(ob | jcb_pkg::SFX_ALU64_X, it.dst, jcb_pkg::REG_AX, '0, '0);
			end else if (!it.op[3] && cls == jcb_pkg::CLS_JMP && jmp_k(ob)) begin
				put(jcb_pkg::OP_MOV64_K, jcb_pkg::REG_AX, '0, '0, masked);
				put(jcb_pkg::OP_XOR64_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
				put(ob | jcb_pkg::SFX_JMP_X, it.dst, jcb_pkg::REG_AX, noff, '0);
			end else if (!it.op[3] && cls == jcb_pkg::CLS_JMP32 && jmp_k(ob)) begin
				put(jcb_pkg::OP_MOV32_K, jcb_pkg::REG_AX, '0, '0, masked);
				put(jcb_pkg::OP_XOR32_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
				put(ob | jcb_pkg::SFX_JMP32_X, it.dst, jcb_pkg::REG_AX, noff, '0);
			end else if (it.op == jcb_pkg::OP_ST_W || it.op == jcb_pkg::OP_ST_H ||
					it.op == jcb_pkg::OP_ST_B || it.op == jcb_pkg::OP_ST_DW) begin
				put(jcb_pkg::OP_MOV64_K, jcb_pkg::REG_AX, '0, '0, masked);
				put(jcb_pkg::OP_XOR64_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
				put((it.op & jcb_pkg::ST_SIZE_MASK) | jcb_pkg::STX_MEM_BASE, it.dst,
					jcb_pkg::REG_AX, it.off, '0);
			end else begin
				put_raw(it);
			end
		endfunction

		function void take_insn(insn_t it);
			bit plain;
			rewr_t tail;
			plain = 1'b1;
			run_q.delete();
			if (skip_next_insn) begin
				skip_next_insn = 1'b0;
				put_raw(it);
				plain = 1'b0;
			end else if (held_valid) begin
				held_valid = 1'b0;
				if (it.op == jcb_pkg::OP_LD_SECOND) begin
					put(jcb_pkg::OP_MOV64_K, jcb_pkg::REG_AX, '0, '0, held_rnd ^ it.imm);
					put(jcb_pkg::OP_XOR64_K, jcb_pkg::REG_AX, '0, '0, held_rnd);
					put(jcb_pkg::OP_LSH64_K, jcb_pkg::REG_AX, '0, '0, jcb_pkg::AX_SHIFT);
					put(jcb_pkg::OP_MOV64_X, held_dst, jcb_pkg::REG_AX, '0, '0);
					if (uses_ax(it)) begin
						put_raw(it);
					end else begin
						put(jcb_pkg::OP_MOV32_K, jcb_pkg::REG_AX, '0, '0, it.rnd ^ held_imm);
						put(jcb_pkg::OP_XOR32_K, jcb_pkg::REG_AX, '0, '0, it.rnd);
						if (zext_en)
							put(jcb_pkg::OP_MOV32_X, jcb_pkg::REG_AX, jcb_pkg::REG_AX, '0,
								jcb_pkg::ZEXT_IMM);
						put(jcb_pkg::OP_OR64_X, held_dst, jcb_pkg::REG_AX, '0, '0);
					end
					plain = 1'b0;
				end else begin
					put(jcb_pkg::OP_LD_IMM64, held_dst, held_src, held_off, held_imm);
				end
			end
			if (plain) begin
				if (!blind_en || it.op == jcb_pkg::OP_LD_SECOND) begin
					put_raw(it);
				end else if (it.op == jcb_pkg::OP_LD_IMM64) begin
					if (it.src == jcb_pkg::PSEUDO_FUNC || uses_ax(it)) begin
						put_raw(it);
						skip_next_insn = 1'b1;
					end else if (it.eop) begin
						put_raw(it);
					end else begin
						held_valid = 1'b1;
						held_dst = it.dst;
						held_src = it.src;
						held_off = it.off;
						held_imm = it.imm;
						held_rnd = it.rnd;
					end
				end else begin
					blind_one(it);
				end
			end
			if (it.eop) begin
				held_valid = 1'b0;
				skip_next_insn = 1'b0;
			end
			if (run_q.size() > 0) begin
				tail = run_q.pop_back();
				tail.last = 1'b1;
				run_q.push_back(tail);
			end
			foreach (run_q[i])
				rewrites_due.push_back(run_q[i]);
		endfunction

		function void check_emitted(rewr_t got);
			rewr_t want;
			if (rewrites_due.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected instruction op=%h dst=%h src=%h off=%h imm=%h last=%b",
						got.op, got.dst, got.src, got.off, got.imm, got.last);
				mismatch_count++;
			end else begin
				want = rewrites_due.pop_front();
				if (got.op !== want.op || got.dst !== want.dst || got.src !== want.src ||
						got.off !== want.off || got.imm !== want.imm || got.last !== want.last) begin
					if (mismatch_count < 10) begin
						$display("mismatch: expected op=%h dst=%h src=%h off=%h imm=%h last=%b",
							want.op, want.dst, want.src, want.off, want.imm, want.last);
						$display("          actual   op=%h dst=%h src=%h off=%h imm=%h last=%b",
							got.op, got.dst, got.src, got.off, got.imm, got.last);
					end
					mismatch_count++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] opcode;
	logic [3:0] dest_reg;
	logic [3:0] source_reg;
	logic signed [15:0] offset;
	logic signed [31:0] immediate;
	logic [31:0] random_word;
	logic end_of_program;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_opcode;
	logic [3:0] out_dest;
	logic [3:0] out_source;
	logic signed [15:0] out_offset;
	logic signed [31:0] out_immediate;
	logic last_of_run;

	rewrite_scoreboard sb;
	int burst_left = 0;
	int stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	jit_constant_blinding_rewriter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.dest_reg(dest_reg),
		.source_reg(source_reg),
		.offset(offset),
		.immediate(immediate),
		.random_word(random_word),
		.end_of_program(end_of_program),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_opcode(out_opcode),
		.out_dest(out_dest),
		.out_source(out_source),
		.out_offset(out_offset),
		.out_immediate(out_immediate),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(4, 40);
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_emitted({out_opcode, out_dest, out_source, out_offset, out_immediate,
				last_of_run});
	end

	function automatic insn_t insn(logic [7:0] op, logic [3:0] dst, logic [3:0] src,
			logic [15:0] off, logic [31:0] imm, logic [31:0] rnd, logic eop);
		insn_t it;
		it.op = op;
		it.dst = dst;
		it.src = src;
		it.off = off;
		it.imm = imm;
		it.rnd = rnd;
		it.eop = eop;
		return it;
	endfunction

	function automatic logic [3:0] pick_reg();
		logic [3:0] r;
		r = 4'($urandom_range(0, 14));
		if (r >= jcb_pkg::REG_AX)
			r = r + 4'd1;
		return r;
	endfunction

	function automatic insn_t rand_fields(logic [7:0] op);
		return insn(op, pick_reg(), pick_reg(), 16'($urandom()), $urandom(), $urandom(),
			$urandom_range(0, 19) == 0);
	endfunction

	function automatic insn_t rand_alu();
		logic [7:0] ob;
		logic [2:0] cls;
		insn_t it;
		case ($urandom_range(0, 8))
			0: ob = jcb_pkg::ALU_ADD;
			1: ob = jcb_pkg::ALU_SUB;
			2: ob = jcb_pkg::ALU_MUL;
			3: ob = jcb_pkg::ALU_DIV;
			4: ob = jcb_pkg::ALU_OR;
			5: ob = jcb_pkg::ALU_AND;
			6: ob = jcb_pkg::ALU_MOD;
			7: ob = jcb_pkg::ALU_XOR;
			default: ob = jcb_pkg::ALU_MOV;
		endcase
		cls = $urandom_range(0, 1) ? jcb_pkg::CLS_ALU64 : jcb_pkg::CLS_ALU;
		it = rand_fields({ob[7:4], 1'b0, cls});
		if ($urandom_range(0, 5) == 0)
			it.imm = 32'd0;
		return it;
	endfunction

	function automatic insn_t rand_jmp();
		logic [7:0] ob;
		logic [2:0] cls;
		case ($urandom_range(0, 10))
			0: ob = jcb_pkg::JMP_JEQ;
			1: ob = jcb_pkg::JMP_JGT;
			2: ob = jcb_pkg::JMP_JGE;
			3: ob = jcb_pkg::JMP_JSET;
			4: ob = jcb_pkg::JMP_JNE;
			5: ob = jcb_pkg::JMP_JSGT;
			6: ob = jcb_pkg::JMP_JSGE;
			7: ob = jcb_pkg::JMP_JLT;
			8: ob = jcb_pkg::JMP_JLE;
			9: ob = jcb_pkg::JMP_JSLT;
			default: ob = jcb_pkg::JMP_JSLE;
		endcase
		cls = $urandom_range(0, 1) ? jcb_pkg::CLS_JMP32 : jcb_pkg::CLS_JMP;
		return rand_fields({ob[7:4], 1'b0, cls});
	endfunction

	function automatic insn_t rand_st();
		case ($urandom_range(0, 3))
			0: return rand_fields(jcb_pkg::OP_ST_W);
			1: return rand_fields(jcb_pkg::OP_ST_H);
			2: return rand_fields(jcb_pkg::OP_ST_B);
			default: return rand_fields(jcb_pkg::OP_ST_DW);
		endcase
	endfunction

	task automatic send_item(input insn_t it);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= it.op;
		dest_reg <= it.dst;
		source_reg <= it.src;
		offset <= it.off;
		immediate <= it.imm;
		random_word <= it.rnd;
		end_of_program <= it.eop;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				sb.take_insn(it);
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic blind, input logic zext);
		write_reg(jcb_pkg::CFG_BLIND_ENABLE, blind);
		write_reg(jcb_pkg::CFG_ZEXT_ENABLE, zext);
		cfg_we <= 1'b0;
		sb.blind_en = blind;
		sb.zext_en = zext;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.rewrites_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int sent;
		int pick;
		insn_t a;
		insn_t b;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				send_item(rand_alu());
				sent++;
			end else if (pick < 46) begin
				send_item(rand_jmp());
				sent++;
			end else if (pick < 54) begin
				send_item(rand_st());
				sent++;
			end else if (pick < 70) begin
				a = rand_fields(jcb_pkg::OP_LD_IMM64);
				a.eop = 1'b0;
				b = rand_fields(jcb_pkg::OP_LD_SECOND);
				if ($urandom_range(0, 7) == 0)
					b.dst = jcb_pkg::REG_AX;
				send_item(a);
				send_item(b);
				sent += 2;
			end else if (pick < 75) begin
				a = rand_fields(jcb_pkg::OP_LD_IMM64);
				if ($urandom_range(0, 1))
					a.src = jcb_pkg::PSEUDO_FUNC;
				else
					a.dst = jcb_pkg::REG_AX;
				send_item(a);
				send_item(rand_alu());
				sent += 2;
			end else if (pick < 80) begin
				a = rand_fields(jcb_pkg::OP_LD_IMM64);
				a.eop = 1'b0;
				send_item(a);
				send_item(rand_jmp());
				sent += 2;
			end else if (pick < 85) begin
				a = rand_alu();
				if ($urandom_range(0, 1))
					a.dst = jcb_pkg::REG_AX;
				else
					a.src = jcb_pkg::REG_AX;
				send_item(a);
				sent++;
			end else if (pick < 89) begin
				a = rand_fields($urandom_range(0, 1) ? jcb_pkg::OP_MOV64_K : jcb_pkg::OP_MOV32_K);
				a.imm = 32'd0;
				send_item(a);
				sent++;
			end else begin
				send_item(insn(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 16'($urandom()), $urandom(), $urandom(),
					1'($urandom_range(0, 1))));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		opcode = '0;
		dest_reg = '0;
		source_reg = '0;
		offset = '0;
		immediate = '0;
		random_word = '0;
		end_of_program = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(1'b1, 1'b1);
		send_item(insn(OP_ADD64_K, 4'd0, 4'd0, 16'h0000, 32'h7fffffff, 32'h00000000, 1'b0));
		send_item(insn(OP_ADD32_K, 4'd15, 4'd15, 16'h7fff, 32'h80000000, 32'hffffffff, 1'b0));
		send_item(insn(jcb_pkg::OP_MOV64_K, 4'd3, 4'd0, 16'h0000, 32'h00000000, 32'h5a5a5a5a,
			1'b0));
		send_item(insn(jcb_pkg::OP_MOV32_K, 4'd12, 4'd0, 16'h0000, 32'h00000000, 32'ha5a5a5a5,
			1'b0));
		send_item(insn(OP_JEQ_K, 4'd2, 4'd0, 16'hfffb, 32'hffffffff, 32'h0f0f0f0f, 1'b0));
		send_item(insn(OP_JSLT32_K, 4'd5, 4'd0, 16'h8000, 32'h00000000, 32'hf0f0f0f0, 1'b0));
		send_item(insn(OP_JGT_K, 4'd6, 4'd0, 16'h7fff, 32'h00000001, 32'h12345678, 1'b0));
		send_item(insn(jcb_pkg::OP_ST_W, 4'd10, 4'd0, 16'h8000, 32'h12345678, 32'h87654321,
			1'b0));
		send_item(insn(OP_ADD64_K, jcb_pkg::REG_AX, 4'd0, 16'h0000, 32'h00000042, 32'h11111111,
			1'b0));
		send_item(insn(OP_JEQ_K, 4'd1, jcb_pkg::REG_AX, 16'hffff, 32'h00000007, 32'h22222222,
			1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd2, 4'd0, 16'h0000, 32'hdeadbeef, 32'hcafef00d,
			1'b0));
		send_item(insn(jcb_pkg::OP_LD_SECOND, 4'd0, 4'd0, 16'h0000, 32'h01234567, 32'h76543210,
			1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd1, jcb_pkg::PSEUDO_FUNC, 16'h0000, 32'h00000010,
			32'h3, 1'b0));
		send_item(insn(OP_ADD64_K, 4'd4, 4'd0, 16'h0000, 32'h00000099, 32'h44444444, 1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd6, 4'd0, 16'h0000, 32'h00000abc, 32'h55555555,
			1'b0));
		send_item(insn(OP_JA, 4'd0, 4'd0, 16'h0003, 32'h00000000, 32'h66666666, 1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd8, 4'd0, 16'h0000, 32'h0000beef, 32'h77777777,
			1'b1));
		send_item(insn(jcb_pkg::OP_LD_SECOND, 4'd0, 4'd0, 16'h0000, 32'h00000055, 32'h88888888,
			1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd7, 4'd0, 16'h0000, 32'h00001234, 32'h99999999,
			1'b0));
		send_item(insn(jcb_pkg::OP_LD_SECOND, jcb_pkg::REG_AX, 4'd0, 16'h0000, 32'h00005678,
			32'haaaaaaaa, 1'b0));
		send_item(insn(jcb_pkg::OP_LD_IMM64, jcb_pkg::REG_AX, 4'd0, 16'h0000, 32'h00000001,
			32'hbbbbbbbb, 1'b0));
		send_item(insn(jcb_pkg::OP_MOV64_K, 4'd9, 4'd0, 16'h0000, 32'h00000005, 32'hcccccccc,
			1'b0));
		send_item(insn(jcb_pkg::OP_LSH64_K, 4'd3, 4'd0, 16'h0000, 32'h00000004, 32'hdddddddd,
			1'b0));
		send_item(insn(OP_CALL, 4'd0, 4'd0, 16'h0000, 32'h0000000c, 32'heeeeeeee, 1'b0));
		send_item(insn(OP_EXIT, 4'd0, 4'd0, 16'h0000, 32'h00000000, 32'h01010101, 1'b1));
		send_item(insn(jcb_pkg::OP_LD_IMM64, 4'd9, 4'd1, 16'h0000, 32'hfedcba98, 32'h02020202,
			1'b0));
		drain();

		// pair completes blinded although blinding is now off
		apply_settings(1'b0, 1'b1);
		send_item(insn(jcb_pkg::OP_LD_SECOND, 4'd0, 4'd0, 16'h0000, 32'h89abcdef, 32'h13579bdf,
			1'b0));
		random_phase(30);
		drain();
		apply_settings(1'b1, 1'b0);
		random_phase(35);
		drain();
		apply_settings(1'b1, 1'b1);
		random_phase(50);
		drain();
		apply_settings(1'b0, 1'b0);
		random_phase(15);
		drain();
		apply_settings(1'b1, 1'b0);
		random_phase(15);
		drain();

		if (sb.mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
